@@ rtl/rgr_pkg.sv @@
// Shared types and constants for the restricted graph reachability unit.
// No dependencies; every rtl file imports this package.
package rgr_pkg;

  localparam int NODE_W          = 6;
  localparam int ROW_W           = 64;
  localparam int REGIONS_DEFAULT = 64;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_NBR   = 2'd1,
    REQ_REACH = 2'd2,
    REQ_RSVD  = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_NBR_WAIT,
    ST_SEARCH,
    ST_MERGE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;     // latch the accepted input word
    logic write_row;   // store the row and mark the node present
    logic set_res;     // load result register with res_answer/res_status
    logic res_answer;
    logic res_status;
    logic read_start;  // read the start node's row
    logic nbr_result;  // take answer from the row read
    logic walk_init;   // seed reached and pending sets
    logic pick;        // pop lowest pending node, read its row
    logic merge;       // fold row read into reached and pending sets
    logic emit;        // move result into the output register
  } rgr_cmd_t;

  typedef struct packed {
    req_kind_t kind;
    logic      query_bad;     // a named node is not present
    logic      same_node;
    logic      pending_empty;
    logic      goal_hit;
    logic      out_free;
  } rgr_stat_t;

endpackage

@@ rtl/rgr_ctrl.sv @@
// Controller state machine for the reachability unit.
// Depends on rgr_pkg; drives rgr_dp through rgr_cmd_t, reads rgr_stat_t.
module rgr_ctrl
  import rgr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  rgr_stat_t stat,
  output rgr_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat.kind)
          REQ_NBR: begin
            state_next = stat.query_bad ? ST_FINISH : ST_NBR_WAIT;
          end
          REQ_REACH: begin
            state_next = (stat.query_bad || stat.same_node) ? ST_FINISH : ST_SEARCH;
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_NBR_WAIT: state_next = ST_FINISH;
      ST_SEARCH: begin
        state_next = (stat.goal_hit || stat.pending_empty) ? ST_FINISH : ST_MERGE;
      end
      ST_MERGE: state_next = ST_SEARCH;
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_DECODE: begin
        cmd.set_res = 1'b1;
        unique case (stat.kind)
          REQ_LOAD: cmd.write_row = 1'b1;
          REQ_NBR: begin
            cmd.res_status = stat.query_bad;
            cmd.read_start = !stat.query_bad;
          end
          REQ_REACH: begin
            cmd.res_status = stat.query_bad;
            cmd.res_answer = !stat.query_bad && stat.same_node;
            cmd.walk_init  = !stat.query_bad && !stat.same_node;
          end
          default: ;
        endcase
      end
      ST_NBR_WAIT: cmd.nbr_result = 1'b1;
      ST_SEARCH: begin
        if (stat.goal_hit || stat.pending_empty) begin
          cmd.set_res    = 1'b1;
          cmd.res_answer = stat.goal_hit;
        end else begin
          cmd.pick = 1'b1;
        end
      end
      ST_MERGE:  cmd.merge = 1'b1;
      ST_FINISH: cmd.emit  = stat.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/rgr_dp.sv @@
// Datapath: row memory, present flags, walk sets, result and output registers.
// Depends on rgr_pkg; steered by rgr_ctrl through rgr_cmd_t.
module rgr_dp
  import rgr_pkg::*;
#(
  parameter int REGIONS = REGIONS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  rgr_cmd_t          cmd,
  output rgr_stat_t         stat,
  input  logic [1:0]        req_type,
  input  logic [NODE_W-1:0] first_region,
  input  logic [NODE_W-1:0] second_region,
  input  logic [ROW_W-1:0]  row_bits,
  input  logic [ROW_W-1:0]  allowed_mask,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              answer,
  output logic              status
);

  localparam int AW = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  logic [REGIONS-1:0] rows [REGIONS];
  logic [REGIONS-1:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;

  req_kind_t          kind_q;
  logic [NODE_W-1:0]  a_q, b_q;
  logic [REGIONS-1:0] row_q, allow_q;
  logic [REGIONS-1:0] present, usable, reached, pending;
  logic               res_answer, res_status;

  logic               a_ok, b_ok, a_present, b_present;
  logic [REGIONS-1:0] low_bit, grown, start_bit;
  logic [AW-1:0]      pick_idx;

  // lowest pending node: isolate the low set bit, then encode it
  assign low_bit = pending & (~pending + {{(REGIONS-1){1'b0}}, 1'b1});

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < REGIONS; i++) begin
      pick_idx = pick_idx | (low_bit[i] ? AW'(i) : '0);
    end
  end

  assign a_ok      = {1'b0, a_q} < (NODE_W+1)'(REGIONS);
  assign b_ok      = {1'b0, b_q} < (NODE_W+1)'(REGIONS);
  assign a_present = a_ok && present[a_q[AW-1:0]];
  assign b_present = b_ok && present[b_q[AW-1:0]];

  assign start_bit = {{(REGIONS-1){1'b0}}, 1'b1} << a_q[AW-1:0];

  assign grown = rd_data & usable & ~reached;

  assign rd_en   = cmd.read_start || cmd.pick;
  assign rd_addr = cmd.pick ? pick_idx : a_q[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.write_row && a_ok) rows[a_q[AW-1:0]] <= row_q;
    if (rd_en) rd_data <= rows[rd_addr];
  end

  // latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= req_kind_t'(req_type);
      a_q     <= first_region;
      b_q     <= second_region;
      row_q   <= row_bits[REGIONS-1:0];
      allow_q <= allowed_mask[REGIONS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      reached <= '0;
      pending <= '0;
      usable  <= '0;
    end else begin
      if (cmd.write_row && a_ok) present[a_q[AW-1:0]] <= 1'b1;
      if (cmd.walk_init) begin
        reached <= start_bit;
        pending <= start_bit;
        usable  <= allow_q & present;
      end else if (cmd.pick) begin
        pending <= pending & ~low_bit;
      end else if (cmd.merge) begin
        reached <= reached | grown;
        pending <= pending | grown;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_answer <= cmd.res_answer;
      res_status <= cmd.res_status;
    end else if (cmd.nbr_result) begin
      res_answer <= rd_data[b_q[AW-1:0]];
      res_status <= 1'b0;
    end
  end

  // output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      answer <= res_answer;
      status <= res_status;
    end
  end

  always_comb begin
    stat.kind          = kind_q;
    stat.query_bad     = !a_present || !b_present;
    stat.same_node     = (a_q == b_q);
    stat.pending_empty = (pending == '0);
    stat.goal_hit      = reached[b_q[AW-1:0]];
    stat.out_free      = !out_valid || !out_stall;
  end

endmodule

@@ rtl/restricted_graph_reachability_unit.sv @@
// Top level of the restricted graph reachability unit.
// Depends on rgr_pkg, rgr_ctrl and rgr_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | req_type, first_region, second_region,
//          |                      | row_bits, allowed_mask
//  out     | out_valid / out_stall| answer, status
//
// One request at a time. A reachability walk pops one pending node and
// merges its row the next cycle, through the single row-memory read port;
// only after that merge does it pop another pending node.
// Reset (rst, synchronous) clears present flags, walk sets and out_valid.
// A result waits in the output register under out_stall while the next word
// is accepted; the block finishes that word only once the register frees up.
module restricted_graph_reachability_unit
  import rgr_pkg::*;
#(
  parameter int REGIONS = REGIONS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [NODE_W-1:0] first_region,
  input  logic [NODE_W-1:0] second_region,
  input  logic [ROW_W-1:0]  row_bits,
  input  logic [ROW_W-1:0]  allowed_mask,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              answer,
  output logic              status
);

  rgr_cmd_t  cmd;
  rgr_stat_t stat;

  rgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rgr_dp #(
    .REGIONS (REGIONS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .first_region  (first_region),
    .second_region (second_region),
    .row_bits      (row_bits),
    .allowed_mask  (allowed_mask),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .answer        (answer),
    .status        (status)
  );

  // after taking a word the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a word was in flight");

  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.pick, cmd.merge, cmd.emit}))
    else $error("controller issued overlapping phases");

  // a pick is always followed by its merge
  a_pick_merge: assert property (@(posedge clk) disable iff (rst)
    cmd.pick |=> cmd.merge)
    else $error("row read not merged");

  a_status_answer: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(answer && status))
    else $error("unknown node reported with a true answer");

endmodule
